@@ sv/bae_pkg.sv @@
package bae_pkg;

   localparam int OP_W   = 4;
   localparam int IDX_W  = 12;
   localparam int SIZE_W = 13;

   typedef enum logic [OP_W-1:0] {
      OP_SET       = 4'd0,
      OP_CLEAR     = 4'd1,
      OP_TEST      = 4'd2,
      OP_SET_RNG   = 4'd3,
      OP_CLR_RNG   = 4'd4,
      OP_ALL_SET   = 4'd5,
      OP_ALL_CLR   = 4'd6,
      OP_FIND_LS   = 4'd7,
      OP_FIND_HS   = 4'd8,
      OP_FIND_LC   = 4'd9,
      OP_FIND_HC   = 4'd10,
      OP_ALLOC     = 4'd11,
      OP_SET_ALL   = 4'd12,
      OP_ANY_SET   = 4'd13
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM_RD,
      ST_TRIM_WR,
      ST_START,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic trim_rd;
      logic trim_wr;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic trim_pend;
      logic args_ok;
      logic walk_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

@@ sv/bae_req_if.sv @@
interface bae_req_if;
   import bae_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [IDX_W-1:0]    low_index;
   logic [IDX_W-1:0]    high_index;

   modport source (output valid, output op, output low_index, output high_index, input ready);
   modport sink (input valid, input op, input low_index, input high_index, output ready);
endinterface

@@ sv/bae_rsp_if.sv @@
interface bae_rsp_if;
   import bae_pkg::*;

   logic                valid;
   logic                ready;
   logic                ok;
   logic                flag;
   logic [IDX_W-1:0]    found_index;

   modport source (output valid, output ok, output flag, output found_index, input ready);
   modport sink (input valid, input ok, input flag, input found_index, output ready);
endinterface

@@ sv/bae_ctrl.sv @@
module bae_ctrl
   import bae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a pending trim from a size write goes first
            if (stat.trim_pend) begin
               state_in = ST_TRIM_RD;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_TRIM_RD: begin
            cmd.trim_rd = 1'b1;
            state_in    = ST_TRIM_WR;
         end
         ST_TRIM_WR: begin
            cmd.trim_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_START: begin
            if (stat.args_ok) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/bae_datapath.sv @@
module bae_datapath
   import bae_pkg::*;
#(
   parameter int MAX_BITS  = 4096,
   parameter int WORD_BITS = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output ctrl_stat_type     stat,
   input  logic [OP_W-1:0]   req_op,
   input  logic [IDX_W-1:0]  req_low_index,
   input  logic [IDX_W-1:0]  req_high_index,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic              rsp_flag,
   output logic [IDX_W-1:0]  rsp_found_index
);

   localparam int WORDS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int B_W      = $clog2(WORD_BITS);
   localparam int SIZE_RST = (MAX_BITS < 4096) ? MAX_BITS : 4096;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type ALL_ONES = '1;

   function automatic logic [B_W-1:0] low_pos(input word_type v);
      logic [B_W-1:0] p;
      p = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (v[j]) p = B_W'(j);
      end
      return p;
   endfunction

   function automatic logic [B_W-1:0] high_pos(input word_type v);
      logic [B_W-1:0] p;
      p = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (v[j]) p = B_W'(j);
      end
      return p;
   endfunction

   // storage
   word_type               mem [WORDS];
   logic [WORDS-1:0]       valid_ff;
   word_type               rd_data_ff;
   logic                   rd_vld_ff;
   logic [WA_W-1:0]        rd_addr;
   logic                   mem_we;
   logic [WA_W-1:0]        wr_addr;
   word_type               wr_data;

   logic [SIZE_W-1:0]      size_ff;
   logic [SIZE_W-1:0]      size_new;
   logic                   trim_pend_ff;
   logic [WA_W-1:0]        trim_word_ff;

   // command registers
   op_type                 op_ff;
   logic                   args_ok_ff;
   logic [WA_W-1:0]        lo_word_ff, hi_word_ff, cur_word_ff;
   logic [B_W-1:0]         lo_bit_ff, hi_bit_ff;
   logic                   flag_all_ff;
   logic                   hit_ff;
   logic [SIZE_W-1:0]      found_ff;

   // decode of the incoming word
   op_type                 in_op;
   logic [SIZE_W-1:0]      in_lo, in_hi, lo_arg, hi_arg;
   logic                   in_ok;

   // per-word evaluation
   word_type               word, mask, sel, hitv;
   logic                   want_set, down, viol, hit_now, last, needs_hit;
   logic [B_W-1:0]         pos;
   logic [WA_W-1:0]        next_word;
   logic                   res_ok;

   assign in_op  = op_type'(req_op);
   assign lo_arg = SIZE_W'(req_low_index);
   assign hi_arg = SIZE_W'(req_high_index);

   always_comb begin
      in_lo = lo_arg;
      in_hi = hi_arg;
      in_ok = 1'b0;
      case (in_op)
         OP_SET, OP_CLEAR, OP_TEST: begin
            in_hi = lo_arg;
            in_ok = lo_arg < size_ff;
         end
         OP_SET_RNG, OP_CLR_RNG, OP_ALL_SET, OP_ALL_CLR,
         OP_FIND_LS, OP_FIND_HS, OP_FIND_LC, OP_FIND_HC: begin
            in_ok = (lo_arg <= hi_arg) && (hi_arg < size_ff);
         end
         OP_ALLOC, OP_SET_ALL, OP_ANY_SET: begin
            in_lo = '0;
            in_hi = size_ff - SIZE_W'(1);
            in_ok = 1'b1;
         end
         default: begin
            in_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      want_set  = 1'b0;
      down      = 1'b0;
      needs_hit = 1'b0;
      case (op_ff)
         OP_TEST, OP_ALL_SET, OP_FIND_LS: want_set = 1'b1;
         OP_FIND_HS: begin
            want_set  = 1'b1;
            down      = 1'b1;
         end
         OP_FIND_HC: down = 1'b1;
         default: want_set = 1'b0;
      endcase
      case (op_ff)
         OP_FIND_LS, OP_FIND_HS, OP_FIND_LC, OP_FIND_HC, OP_ALLOC: needs_hit = 1'b1;
         default: needs_hit = 1'b0;
      endcase
   end

   assign word = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      mask = ALL_ONES;
      if (cur_word_ff == lo_word_ff) mask = mask & (ALL_ONES << lo_bit_ff);
      if (cur_word_ff == hi_word_ff) begin
         mask = mask & (ALL_ONES >> (B_W'(WORD_BITS - 1) - hi_bit_ff));
      end
   end

   assign sel     = want_set ? word : ~word;
   assign hitv    = sel & mask;
   assign viol    = |(~sel & mask);
   assign hit_now = needs_hit && (|hitv);
   assign pos     = down ? high_pos(hitv) : low_pos(hitv);
   assign last    = down ? (cur_word_ff == lo_word_ff) : (cur_word_ff == hi_word_ff);
   assign next_word = down ? cur_word_ff - WA_W'(1) : cur_word_ff + WA_W'(1);

   // write port: walk updates or the trim of a partial word
   always_comb begin
      mem_we  = 1'b0;
      wr_addr = cur_word_ff;
      wr_data = word;
      if (cmd.trim_wr) begin
         mem_we  = 1'b1;
         wr_addr = trim_word_ff;
         if (SIZE_W'(trim_word_ff) * SIZE_W'(WORD_BITS) + SIZE_W'(WORD_BITS) <= size_ff) begin
            wr_data = word;
         end else if (SIZE_W'(trim_word_ff) * SIZE_W'(WORD_BITS) < size_ff) begin
            wr_data = word & ~(ALL_ONES << B_W'(size_ff % WORD_BITS));
         end else begin
            wr_data = '0;
         end
      end else if (cmd.step) begin
         case (op_ff)
            OP_SET, OP_SET_RNG, OP_SET_ALL: begin
               mem_we  = 1'b1;
               wr_data = word | mask;
            end
            OP_CLEAR, OP_CLR_RNG: begin
               mem_we  = 1'b1;
               wr_data = word & ~mask;
            end
            OP_ALLOC: begin
               mem_we  = hit_now;
               wr_data = word | (word_type'(1) << pos);
            end
            default: mem_we = 1'b0;
         endcase
      end
   end

   always_comb begin
      rd_addr = cur_word_ff;
      if (cmd.trim_rd) rd_addr = trim_word_ff;
      else if (cmd.step) rd_addr = next_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // size clamp: zero reads as one, above the bitmap reads as the bitmap
   always_comb begin
      size_new = csr_wdata;
      if (csr_wdata == '0) size_new = SIZE_W'(1);
      else if (int'(csr_wdata) > MAX_BITS) size_new = SIZE_W'(MAX_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         size_ff      <= SIZE_W'(SIZE_RST);
         trim_pend_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_addr];
         if (mem_we) valid_ff[wr_addr] <= 1'b1;
         if (cmd.trim_wr) trim_pend_ff <= 1'b0;
         if (csr_we) begin
            size_ff <= size_new;
            // whole words past the new size drop out at once
            for (int w = 0; w < WORDS; w++) begin
               if (w * WORD_BITS >= int'(size_new)) valid_ff[w] <= 1'b0;
            end
            if ((size_new % WORD_BITS) != 0) begin
               trim_pend_ff <= 1'b1;
               if (!trim_pend_ff || (WA_W'(size_new / WORD_BITS) < trim_word_ff)) begin
                  trim_word_ff <= WA_W'(size_new / WORD_BITS);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= in_op;
         args_ok_ff  <= in_ok;
         lo_word_ff  <= WA_W'(in_lo / WORD_BITS);
         lo_bit_ff   <= B_W'(in_lo % WORD_BITS);
         hi_word_ff  <= WA_W'(in_hi / WORD_BITS);
         hi_bit_ff   <= B_W'(in_hi % WORD_BITS);
         if (in_op == OP_FIND_HS || in_op == OP_FIND_HC) begin
            cur_word_ff <= WA_W'(in_hi / WORD_BITS);
         end else begin
            cur_word_ff <= WA_W'(in_lo / WORD_BITS);
         end
         flag_all_ff <= 1'b1;
         hit_ff      <= 1'b0;
         found_ff    <= '0;
      end else if (cmd.step) begin
         cur_word_ff <= next_word;
         if (viol) flag_all_ff <= 1'b0;
         if (hit_now) begin
            hit_ff   <= 1'b1;
            found_ff <= SIZE_W'(cur_word_ff) * SIZE_W'(WORD_BITS) + SIZE_W'(pos);
         end
      end
   end

   // output register
   assign res_ok = args_ok_ff && (!needs_hit || hit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ok          <= res_ok;
         rsp_flag        <= 1'b0;
         rsp_found_index <= '0;
         if (res_ok) begin
            case (op_ff)
               OP_TEST, OP_ALL_SET, OP_ALL_CLR: rsp_flag <= flag_all_ff;
               OP_ANY_SET: rsp_flag <= !flag_all_ff;
               default: rsp_flag <= 1'b0;
            endcase
            if (needs_hit) rsp_found_index <= found_ff[IDX_W-1:0];
         end
      end
   end

   assign stat.trim_pend = trim_pend_ff;
   assign stat.args_ok   = args_ok_ff;
   assign stat.walk_done = last || hit_now;
   assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

@@ sv/bitmap_allocator_engine.sv @@
// Bitmap allocator engine: a bitmap of MAX_BITS bits in WORD_BITS-bit words.
// req_chan carries one command word (op, low_index, high_index); rsp_chan
// returns exactly one result word (ok, flag, found_index) per command.
// csr_we/csr_wdata write size_in_use; write it only while no command is in
// flight. A size that is not a multiple of WORD_BITS trims the word holding
// the new boundary, which holds req_chan.ready low while that word is trimmed.
// An accepted command passes through start, walk and finish; one with failed
// arguments skips the walk. Single-bit commands walk one word; range, find,
// allocate, set-all and any-set walk the words of their range, at most
// MAX_BITS/WORD_BITS words. The walk reads one stored word per cycle through
// the one read port of the word memory; find and allocate stop at the first hit.
// One command is in flight at a time; the next is taken once the result is in
// the output register, even while rsp_chan is stalled. A stalled result holds
// and the engine waits before loading the next one.
// Reset is synchronous: the bitmap reads as all zero, size_in_use = 4096
// (or MAX_BITS if smaller), and no result is pending.
module bitmap_allocator_engine
   import bae_pkg::*;
#(
   parameter int MAX_BITS  = 4096,
   parameter int WORD_BITS = 64
)
(
   input  logic              clock,
   input  logic              reset,
   bae_req_if.sink           req_chan,
   bae_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   bae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bae_datapath #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_chan.op),
      .req_low_index   (req_chan.low_index),
      .req_high_index  (req_chan.high_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_ok          (rsp_chan.ok),
      .rsp_flag        (rsp_chan.flag),
      .rsp_found_index (rsp_chan.found_index)
   );

endmodule

@@ sv/bae_checker.sv @@
module bae_checker
   import bae_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_ok,
   input logic             rsp_flag,
   input logic [IDX_W-1:0] rsp_found_index
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_flag)
         && $stable(rsp_found_index))
      else $error("stalled result changed");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> !rsp_flag && rsp_found_index == '0)
      else $error("failed result carries data");

   a_flag_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag |-> rsp_found_index == '0)
      else $error("query result carries an index");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

endmodule

bind bitmap_allocator_engine bae_checker u_bae_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_ok          (rsp_chan.ok),
   .rsp_flag        (rsp_chan.flag),
   .rsp_found_index (rsp_chan.found_index)
);
